// ----- hdl/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled clock edge outside reset
`define KSD_ASSERT(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define KSD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ksd_pkg.sv -----
package ksd_pkg;

    // window and keyword table geometry
    localparam int WinDepth = 9;
    localparam int KwCount  = 9;
    localparam int KwMax    = 10;

    typedef logic [7:0] char_t;
    typedef char_t      kw_chars_t [KwMax];

    // keyword characters, lower case, zero padded
    localparam kw_chars_t KwChars [KwCount] = '{
        '{8'h6d, 8'h72, 8'h62, 8'h65, 8'h61, 8'h73, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h70, 8'h72, 8'h61, 8'h6e, 8'h6b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h75, 8'h6e, 8'h6e, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h74, 8'h69, 8'h6b, 8'h74, 8'h6f, 8'h6b, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h75, 8'h72, 8'h76, 8'h69, 8'h76, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h63, 8'h68, 8'h61, 8'h6c, 8'h6c, 8'h65, 8'h6e, 8'h67, 8'h65, 8'h00},
        '{8'h73, 8'h70, 8'h69, 8'h64, 8'h65, 8'h72, 8'h2d, 8'h6d, 8'h61, 8'h6e},
        '{8'h74, 8'h72, 8'h61, 8'h69, 8'h6c, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00}
    };

    // keyword lengths in characters
    localparam logic [3:0] KwLen [KwCount] = '{
        4'd7, 4'd5, 4'd5, 4'd6, 4'd3, 4'd7, 4'd9, 4'd10, 4'd7
    };

    // registered input byte handed to the match core
    typedef struct packed {
        logic  valid;
        logic  last;
        char_t ch;
    } stage_t;

    // result load request from the match core
    typedef struct packed {
        logic load;
        logic found;
    } res_t;

    // ascii upper case to lower case, other bytes unchanged
    function automatic char_t fold_byte(char_t b);
        char_t r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5a)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- hdl/ksd_text_if.sv -----
interface ksd_text_if;
    logic            valid;
    logic            ready;
    ksd_pkg::char_t  char_code;
    logic            last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- hdl/ksd_result_if.sv -----
interface ksd_result_if;
    logic valid;
    logic ready;
    logic keyword_found;

    modport source (output valid, output keyword_found, input ready);
    modport sink   (input valid, input keyword_found, output ready);
endinterface

// ----- hdl/ksd_fold_stage.sv -----
module ksd_fold_stage
(
    input  logic             clk,
    input  logic             rst_n,
    ksd_text_if.sink         text,
    input  logic             take,
    output ksd_pkg::stage_t  item
);

    logic           valid_reg;
    logic           valid_next;
    logic           last_reg;
    ksd_pkg::char_t ch_reg;
    logic           accept;

    // stage is free when empty or when its byte moves on this cycle
    assign text.ready = !valid_reg || take;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // folded byte and end-of-text mark
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= ksd_pkg::fold_byte(text.char_code);
            last_reg <= text.last_char;
        end
    end

    assign item.valid = valid_reg;
    assign item.last  = last_reg;
    assign item.ch    = ch_reg;

endmodule

// ----- hdl/ksd_match_core.sv -----
module ksd_match_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  ksd_pkg::stage_t  item,
    input  logic             out_ok,
    output logic             take,
    output ksd_pkg::res_t    res
);

    ksd_pkg::char_t win_reg  [ksd_pkg::WinDepth];
    ksd_pkg::char_t win_next [ksd_pkg::WinDepth];
    logic           seen_reg;
    logic           seen_next;
    logic           hit;
    logic [ksd_pkg::KwCount-1:0] kw_hit;

    // a last byte waits for room in the result register
    assign take = item.valid && (!item.last || out_ok);

    // compare every keyword ending at the current byte, in parallel
    always_comb
    begin
        for (int k = 0; k < ksd_pkg::KwCount; k++)
        begin
            kw_hit[k] = (item.ch == ksd_pkg::KwChars[k][int'(ksd_pkg::KwLen[k]) - 1]);
            for (int i = 0; i < ksd_pkg::KwMax - 1; i++)
            begin
                if (i < int'(ksd_pkg::KwLen[k]) - 1)
                begin
                    if (win_reg[i] != ksd_pkg::KwChars[k][int'(ksd_pkg::KwLen[k]) - 2 - i])
                    begin
                        kw_hit[k] = 1'b0;
                    end
                end
            end
        end
    end

    assign hit = |kw_hit;

    // window shift, sticky flag and clear at end of text
    always_comb
    begin
        win_next  = win_reg;
        seen_next = seen_reg;
        if (take)
        begin
            if (item.last)
            begin
                for (int i = 0; i < ksd_pkg::WinDepth; i++)
                begin
                    win_next[i] = '0;
                end
                seen_next = 1'b0;
            end
            else
            begin
                for (int i = 1; i < ksd_pkg::WinDepth; i++)
                begin
                    win_next[i] = win_reg[i-1];
                end
                win_next[0] = item.ch;
                seen_next   = seen_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ksd_pkg::WinDepth; i++)
            begin
                win_reg[i] <= '0;
            end
            seen_reg <= 1'b0;
        end
        else
        begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
        end
    end

    assign res.load  = take && item.last;
    assign res.found = seen_reg || hit;

endmodule

// ----- hdl/keyword_substring_detector.sv -----
// channel   dir   transaction payload
// text      in    char_code[7:0], last_char
// result    out   keyword_found
//
// one byte per cycle while no last byte waits on a stalled result; a byte
// passes the input register, then the window compare, and the compare of
// the last byte of a text loads the result into the output register
// rst_n clears the window, the match flag and all valid flags
// a stalled result holds input only once a last byte reaches the compare
module keyword_substring_detector
(
    input  logic         clk,
    input  logic         rst_n,
    ksd_text_if.sink     text,
    ksd_result_if.source result
);

    ksd_pkg::stage_t item;
    ksd_pkg::res_t   res;
    logic            take;
    logic            out_ok;
    logic            out_valid_reg;
    logic            found_reg;

    // output register can take a result when empty or being drained
    assign out_ok = !out_valid_reg || result.ready;

    ksd_fold_stage u_fold
    (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .take  (take),
        .item  (item)
    );

    ksd_match_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .out_ok (out_ok),
        .take   (take),
        .res    (res)
    );

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ok)
        begin
            out_valid_reg <= res.load;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            found_reg <= res.found;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.keyword_found = found_reg;

endmodule

// ----- hdl/ksd_checker.sv -----
`include "assert_macros.svh"

module ksd_checker
(
    input logic clk,
    input logic rst_n,
    input logic text_valid,
    input logic text_ready,
    input logic text_last,
    input logic res_valid,
    input logic res_ready,
    input logic res_found
);

    // a stalled result stays and keeps its value
    `KSD_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_found), "stalled result changed")

    // input is never refused while the result register is empty
    `KSD_ASSERT(a_ready_when_empty, clk, rst_n, !res_valid |-> text_ready, "input refused with empty output")

    // a new result is always preceded by an accepted last byte
    `KSD_ASSERT(a_res_after_last, clk, rst_n, $rose(res_valid) |-> $past(text_valid && text_ready && text_last, 2), "result without a last byte")

    // an accepted last byte with an empty output gives a result
    `KSD_ASSERT(a_last_gives_res, clk, rst_n, (text_valid && text_ready && text_last && !res_valid) |-> ##2 res_valid, "last byte produced no result")

endmodule

bind keyword_substring_detector ksd_checker u_ksd_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .text_last  (text.last_char),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_found  (result.keyword_found)
);
